>>> src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Field widths
  localparam int WORD_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Classified command handed from the front end to the execution side
  typedef struct packed {
    logic                     is_push;
    logic                     at_front;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

>>> src/double_ended_queue_core.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words kept in a ring of DEPTH entries.
// Raise start with in_operation (0 push front, 1 push back, 2 pop front,
// 3 pop back) and in_value; the item is taken on a clock edge where busy is
// low. Every item yields exactly one result, shown for one cycle with
// out_valid high: the popped word (-1 for a push or a pop on an empty
// queue), a status (0 ok, 1 pop on empty, 2 push on full dropped) and the
// entry count after the operation. The receiver cannot stall; results must
// be captured when out_valid is high. Items are taken at one per cycle
// while busy is low: the execution side uses a single ring memory port at
// most once per item, and a two-slot command queue between the decoder and
// the execution side raises busy only when both slots are occupied.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [deq_pkg::OP_W-1:0]              in_operation,
  input  logic signed [deq_pkg::WORD_W-1:0]     in_value,
  output logic                                  out_valid,
  output logic signed [deq_pkg::WORD_W-1:0]     out_popped_value,
  output logic [deq_pkg::STATUS_W-1:0]          out_status,
  output logic [deq_pkg::COUNT_W-1:0]           out_count
);

  logic          q_full;
  logic          q_push;
  deq_pkg::cmd_t q_cmd;
  logic          cmd_valid;
  deq_pkg::cmd_t cmd;

  // Accept and classify
  deq_front u_front (
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_value     (in_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Command queue between front and back
  deq_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd)
  );

  // Ring execution
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

endmodule

>>> src/deq_front.sv
`timescale 1ns / 1ps

module deq_front (
  input  logic                                  start,
  output logic                                  busy,
  input  logic [deq_pkg::OP_W-1:0]              in_operation,
  input  logic signed [deq_pkg::WORD_W-1:0]     in_value,
  input  logic                                  q_full,
  output logic                                  q_push,
  output deq_pkg::cmd_t                         q_cmd
);

  deq_pkg::op_t op;

  assign op = deq_pkg::op_t'(in_operation);

  // Hold off new items while the command queue has no room
  assign busy   = q_full;
  assign q_push = start && !q_full;

  // Classify the operation into direction and end
  always_comb begin
    q_cmd.value = in_value;
    unique case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        q_cmd.is_push  = 1'b1;
        q_cmd.at_front = 1'b1;
      end
      deq_pkg::OP_PUSH_BACK: begin
        q_cmd.is_push  = 1'b1;
        q_cmd.at_front = 1'b0;
      end
      deq_pkg::OP_POP_FRONT: begin
        q_cmd.is_push  = 1'b0;
        q_cmd.at_front = 1'b1;
      end
      deq_pkg::OP_POP_BACK: begin
        q_cmd.is_push  = 1'b0;
        q_cmd.at_front = 1'b0;
      end
      default: begin
        q_cmd.is_push  = 1'b0;
        q_cmd.at_front = 1'b0;
      end
    endcase
  end

endmodule

>>> src/deq_cmd_queue.sv
`timescale 1ns / 1ps

module deq_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  deq_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output deq_pkg::cmd_t pop_cmd
);

  // Two-slot queue; the execution side drains one slot every cycle it is non-empty
  deq_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          pop;

  assign full      = (fill_r == 2'd2);
  assign pop_valid = (fill_r != 2'd0);
  assign pop       = pop_valid;
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/deq_back.sv
`timescale 1ns / 1ps

module deq_back #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  input  deq_pkg::cmd_t                         cmd,
  output logic                                  out_valid,
  output logic signed [deq_pkg::WORD_W-1:0]     out_popped_value,
  output logic [deq_pkg::STATUS_W-1:0]          out_status,
  output logic [deq_pkg::COUNT_W-1:0]           out_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Ring storage, one write or one read per cycle
  logic [deq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [deq_pkg::WORD_W-1:0] rd_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                 out_valid_r;
  deq_pkg::status_t     status_r, status_nxt;
  logic [deq_pkg::COUNT_W-1:0] out_count_r;
  logic                 use_rd_r, use_rd_nxt;

  logic             is_full, is_empty;
  logic [IDX_W-1:0] head_dec, head_inc;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_pos;
  logic [IDX_W-1:0] addr;
  logic             wr_en, rd_en;
  logic [CNT_W+deq_pkg::COUNT_W-1:0] count_ext;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Neighbor positions of the head with wrap
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // Back position: first free slot for a push, last entry for a pop
  always_comb begin
    offset   = cmd.is_push ? count_r : count_r - 1'b1;
    tail_sum = SUM_W'(head_r) + SUM_W'(offset);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_pos = IDX_W'(tail_sum - SUM_W'(DEPTH));
    end else begin
      tail_pos = IDX_W'(tail_sum);
    end
  end

  // Execute one command
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = deq_pkg::ST_OK;
    use_rd_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = cmd.at_front ? (cmd.is_push ? head_dec : head_r) : tail_pos;
    if (cmd_valid) begin
      if (cmd.is_push) begin
        if (is_full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          if (cmd.at_front) begin
            head_nxt = head_dec;
          end
        end
      end else begin
        if (is_empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          use_rd_nxt = 1'b1;
          count_nxt  = count_r - 1'b1;
          if (cmd.at_front) begin
            head_nxt = head_inc;
          end
        end
      end
    end
  end

  // Count reported in the result field width
  assign count_ext = {{deq_pkg::COUNT_W{1'b0}}, count_nxt};

  // Ring state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    use_rd_r    <= use_rd_nxt;
    out_count_r <= count_ext[deq_pkg::COUNT_W-1:0];
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_count        = out_count_r;
  assign out_popped_value = use_rd_r ? $signed(rd_data_r) : '1;

endmodule
